/* hdl/dd_node_signature_hash_macros.svh */
// Assertion macros shared by the node signature hash modules.
`ifndef DD_NODE_SIGNATURE_HASH_MACROS_SVH
`define DD_NODE_SIGNATURE_HASH_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define DNSH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DNSH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dd_nsh_pkg.sv */
// Shared constants and types of the node signature hash block.
package dd_nsh_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int STRIDE_W    = CNT_W + 1;
    localparam int CHG_W       = CNT_W + 2;

    localparam int IDX_W  = 16;
    localparam int VAL_W  = 31;
    localparam int WORD_W = IDX_W + VAL_W;
    localparam int MOD_W  = 25;
    localparam int HASH_W = 24;
    localparam int DIV_W  = 33;
    localparam int STEP_W = $clog2(DIV_W);

    localparam logic [MOD_W-1:0] MOD_MAX     = MOD_W'(25'h100_0000);
    localparam logic [MOD_W-1:0] TABLE_RESET = MOD_W'(1024);

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] rem;
    } mod_status_t;

endpackage

/* hdl/dd_node_signature_hash.sv */
// Top level of the decision-diagram node signature hash.
// Walk: after the last entry, each visited pair takes one buffer read and two remainder
//   passes (each a start, 33 steps and a done), then the hash goes to the output register.
// Throughput: one entry per cycle while loading; the walk is bound by the shared
//   bit-serial remainder unit, and s_tready stays low until the result is loaded.
// Reset: aresetn, synchronous, active low; clears state, entry count, overflow and output
//   valid, sets table_size to 1024. The pair buffer has no reset; only stored entries are read.
`include "dd_node_signature_hash_macros.svh"

module dd_node_signature_hash (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration: table_size
    input  logic                         cfg_we,
    input  logic [dd_nsh_pkg::MOD_W-1:0] cfg_wdata,
    // entry input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [47:0]                  s_tdata,   // [15:0] entry_index, [46:16] entry_value
    input  logic                         s_tuser,   // [0] mode
    input  logic                         s_tlast,   // last entry of the node
    // hash result
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [23:0] hash_value
    output logic                         m_tuser    // [0] overflow
);
    import dd_nsh_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_START1 = 3'd2;
    localparam logic [2:0] ST_WAIT1  = 3'd3;
    localparam logic [2:0] ST_START2 = 3'd4;
    localparam logic [2:0] ST_WAIT2  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [MOD_W-1:0]    mod_reg, mod_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic [HASH_W-1:0]   acc_reg, acc_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [STRIDE_W-1:0] stride_reg, stride_next;
    logic [CNT_W-1:0]    ops_reg, ops_next;
    logic [CHG_W-1:0]    chg_reg, chg_next;
    logic                out_valid_reg, out_valid_next;
    logic [HASH_W-1:0]   out_hash_reg, out_hash_next;
    logic                out_ovf_reg, out_ovf_next;

    // pair buffer: entry_value above entry_index in each word
    logic [WORD_W-1:0]   pair_mem [MAX_ENTRIES];
    logic [WORD_W-1:0]   rd_word_reg;
    logic                wr_en;

    logic                accept;
    logic                keep;
    logic [IDX_W-1:0]    in_idx;
    logic [VAL_W-1:0]    in_val;
    logic [CNT_W-1:0]    cnt_after;

    logic                mod_start;
    logic [DIV_W-1:0]    mod_x;
    mod_status_t         mod_status;

    logic [CNT_W-1:0]    ops_inc;
    logic                grow;
    logic [STRIDE_W-1:0] stride_new;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_val = s_tdata[IDX_W+VAL_W-1:IDX_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    // full mode drops zero downs, sparse mode keeps every pair
    assign keep     = s_tuser || (in_val != '0);
    assign wr_en    = accept && keep && (cnt_reg < CNT_W'(MAX_ENTRIES));
    assign cnt_after = wr_en ? cnt_reg + CNT_W'(1) : cnt_reg;

    // stride bookkeeping: ops and change point kept with an offset of two
    assign ops_inc    = ops_reg + CNT_W'(1);
    assign grow       = {{(CHG_W-CNT_W){1'b0}}, ops_inc} > chg_reg;
    assign stride_new = stride_reg + STRIDE_W'(grow);

    // operand for the shared remainder unit: (acc * 256 + index) or (acc * 256 + down)
    assign mod_start = (state_reg == ST_START1) || (state_reg == ST_START2);
    always_comb begin
        if (state_reg == ST_START1) begin
            mod_x = {1'b0, acc_reg, 8'b0}
                  + {{(DIV_W-IDX_W){1'b0}}, rd_word_reg[IDX_W-1:0]};
        end else begin
            mod_x = {1'b0, acc_reg, 8'b0}
                  + {{(DIV_W-VAL_W){1'b0}}, rd_word_reg[WORD_W-1:IDX_W]};
        end
    end

    dd_nsh_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .x       (mod_x),
        .m       (mod_reg),
        .status  (mod_status)
    );

    // hold the effective modulus: zero acts as one, anything above 2^24 as 2^24
    always_comb begin
        mod_next = mod_reg;
        if (cfg_we) begin
            if (cfg_wdata == '0) begin
                mod_next = MOD_W'(1);
            end else if (cfg_wdata[MOD_W-1]) begin
                mod_next = MOD_MAX;
            end else begin
                mod_next = cfg_wdata;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        stride_next    = stride_reg;
        ops_next       = ops_reg;
        chg_next       = chg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_hash_next  = out_hash_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next = cnt_after;
                    if (keep && !wr_en) begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        acc_next    = '0;
                        stride_next = STRIDE_W'(1);
                        ops_next    = '0;
                        chg_next    = CHG_W'(4);
                        pos_next    = ADDR_W'(cnt_after - CNT_W'(1));
                        // empty node hashes to zero without a walk
                        state_next  = (cnt_after == '0) ? ST_EMIT : ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_START1;
            end
            ST_START1: begin
                state_next = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (mod_status.done) begin
                    acc_next   = mod_status.rem;
                    state_next = ST_START2;
                end
            end
            ST_START2: begin
                state_next = ST_WAIT2;
            end
            ST_WAIT2: begin
                if (mod_status.done) begin
                    acc_next    = mod_status.rem;
                    ops_next    = ops_inc;
                    stride_next = stride_new;
                    if (grow) begin
                        chg_next = chg_reg + CHG_W'(2);
                    end
                    // step down by the new stride; stop once it passes the first pair
                    if (stride_new > {{(STRIDE_W-ADDR_W){1'b0}}, pos_reg}) begin
                        state_next = ST_EMIT;
                    end else begin
                        pos_next   = pos_reg - stride_new[ADDR_W-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_EMIT: begin
                // load the output register once it is free or being drained
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_hash_next  = acc_reg;
                    out_ovf_next   = ovf_reg;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mod_reg       <= TABLE_RESET;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
        acc_reg      <= acc_next;
        pos_reg      <= pos_next;
        stride_reg   <= stride_next;
        ops_reg      <= ops_next;
        chg_reg      <= chg_next;
        out_hash_reg <= out_hash_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // pair buffer: write at the fill count, read at the walk position every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pair_mem[cnt_reg[ADDR_W-1:0]] <= {in_val, in_idx};
        end
        rd_word_reg <= pair_mem[pos_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;
    assign m_tuser  = out_ovf_reg;

    `DNSH_ASSERT_NOW(a_read_in_range, state_reg == ST_READ,
                     {{(CNT_W-ADDR_W){1'b0}}, pos_reg} < cnt_reg, "walk reads an unstored pair")
    `DNSH_ASSERT_NOW(a_done_when_waiting, mod_status.done,
                     (state_reg == ST_WAIT1) || (state_reg == ST_WAIT2),
                     "remainder finished outside a wait state")
    `DNSH_ASSERT_NEXT(a_overflow_flag, accept && keep && (cnt_reg == CNT_W'(MAX_ENTRIES)),
                      ovf_reg, "dropped pair did not raise overflow")

endmodule

/* hdl/dd_nsh_mod_unit.sv */
// Bit-serial remainder unit: rem = x mod m, one quotient bit per cycle.
`include "dd_node_signature_hash_macros.svh"

module dd_nsh_mod_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dd_nsh_pkg::DIV_W-1:0]  x,
    input  logic [dd_nsh_pkg::MOD_W-1:0]  m,
    output dd_nsh_pkg::mod_status_t       status
);
    import dd_nsh_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  x_reg, x_next;
    logic [HASH_W-1:0] r_reg, r_next;
    logic [MOD_W-1:0]  trial;
    logic [MOD_W-1:0]  diff;

    // shift in the next dividend bit, subtract the modulus when it fits
    assign trial = {r_reg, x_reg[DIV_W-1]};
    assign diff  = trial - m;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_W - 1);
            x_next    = x;
            r_next    = '0;
        end else if (busy_reg) begin
            x_next    = {x_reg[DIV_W-2:0], 1'b0};
            r_next    = (trial >= m) ? diff[HASH_W-1:0] : trial[HASH_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        x_reg <= x_next;
        r_reg <= r_next;
    end

    assign status.done = done_reg;
    assign status.rem  = r_reg;

    `DNSH_ASSERT_NOW(a_no_restart, start, !busy_reg, "mod unit restarted while busy")
    `DNSH_ASSERT_NEXT(a_start_busy, start, busy_reg && !done_reg, "mod unit did not start")
    `DNSH_ASSERT_NEXT(a_finish, busy_reg && (step_reg == '0) && !start,
                      done_reg && !busy_reg, "mod unit did not finish on last step")

endmodule

/* tb/sv/dd_node_signature_hash_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the node signature hash: directed table, then random nodes.
module dd_node_signature_hash_tb;
    import dd_nsh_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int CFG_GUARD    = 80;    // roughly one visited pair of the walk
    localparam int DRAIN_CYCLES = 200;
    localparam int RAND_CHUNKS  = 8;
    localparam int CHUNK_ITEMS  = 92;
    localparam int BIG_CHUNK    = 4;
    localparam int BIG_NODE     = MAX_ENTRIES + 14;  // enough kept pairs to overflow
    localparam int DIR_ROWS     = 23;

    // One hash result as it leaves the block.
    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic              overflow;
    } node_result_t;

    // One row of the directed table: a table_size write or one entry transfer.
    typedef struct packed {
        logic              wr_cfg;
        logic [MOD_W-1:0]  cfg_value;
        logic              mode;
        logic [IDX_W-1:0]  entry_index;
        logic [VAL_W-1:0]  entry_value;
        logic              last;
        logic              fixed;       // expectation is typed into the row
        logic [HASH_W-1:0] hash_value;
        logic              overflow;
    } dir_row_t;

    // Fields: wr_cfg, cfg_value, mode, entry_index, entry_value, last, fixed, hash, overflow.
    dir_row_t dir_rows [DIR_ROWS] = '{
        // empty node: the only entry is a zero down in full mode, so it is dropped
        '{1'b0, 25'd0, 1'b0, 16'h0000, 31'h0000_0000, 1'b1, 1'b1, 24'h0, 1'b0},
        // sparse zero pair at index zero folds to zero
        '{1'b0, 25'd0, 1'b1, 16'h0000, 31'h0000_0000, 1'b1, 1'b1, 24'h0, 1'b0},
        // largest index and down in a one-entry node
        '{1'b0, 25'd0, 1'b0, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, 24'h0, 1'b0},
        // mixed node: sparse zero kept, full zero dropped
        '{1'b0, 25'd0, 1'b1, 16'h0001, 31'h0000_0005, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b1, 16'h0002, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b0, 16'h0003, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b0, 16'h0004, 31'h0000_0009, 1'b1, 1'b0, 24'h0, 1'b0},
        // every entry dropped: empty again
        '{1'b0, 25'd0, 1'b0, 16'h0007, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b0, 16'h0008, 31'h0000_0000, 1'b1, 1'b1, 24'h0, 1'b0},
        // table size zero behaves as one: every hash is zero
        '{1'b1, 25'd0, 1'b0, 16'h0000, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b1, 16'h000A, 31'h0000_0003, 1'b1, 1'b1, 24'h0, 1'b0},
        // table size one
        '{1'b1, 25'd1, 1'b0, 16'h0000, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b0, 16'h04D2, 31'h0000_0001, 1'b1, 1'b1, 24'h0, 1'b0},
        // largest legal table size
        '{1'b1, 25'h100_0000, 1'b0, 16'h0000, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b0, 16'h8000, 31'h4000_0000, 1'b1, 1'b0, 24'h0, 1'b0},
        // table size above the cap clamps to the largest legal size
        '{1'b1, 25'h1FF_FFFF, 1'b0, 16'h0000, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b0, 16'h8000, 31'h4000_0000, 1'b1, 1'b0, 24'h0, 1'b0},
        // tiny table
        '{1'b1, 25'd2, 1'b0, 16'h0000, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0},
        '{1'b0, 25'd0, 1'b1, 16'h5555, 31'h2AAA_AAAA, 1'b1, 1'b0, 24'h0, 1'b0},
        // back to the reset size
        '{1'b1, 25'd1024, 1'b0, 16'h0000, 31'h0000_0000, 1'b0, 1'b0, 24'h0, 1'b0}
    };

    // Idle percentages per phase: none, sender idle, receiver stall, both light.
    int src_idle_by_phase  [4] = '{0, 80, 0, 8};
    int sink_stall_by_phase[4] = '{0, 0, 80, 8};

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [MOD_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [23:0]         m_tdata;
    logic                m_tuser;

    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;

    // Predictor state: pair buffer, pair count, overflow flag and the table size as written.
    logic [IDX_W-1:0]    pair_idx_q [MAX_ENTRIES];
    logic [VAL_W-1:0]    pair_val_q [MAX_ENTRIES];
    int                  pair_total    = 0;
    logic                pair_overflow = 1'b0;
    logic [MOD_W-1:0]    table_size_q  = TABLE_RESET;

    // Hashes still owed by the block, oldest first.
    node_result_t        node_hash_queue [$];

    dd_node_signature_hash u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] entry_index, [46:16] entry_value
        .s_tuser   (s_tuser),    // [0] mode
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [23:0] hash_value
        .m_tuser   (m_tuser)     // [0] overflow
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Walk the stored pairs from newest to oldest with a growing stride and fold each
    // visited pair into the running hash modulo the clamped table size.
    function automatic logic [HASH_W-1:0] fold_node_hash();
        longint unsigned modulus;
        longint unsigned acc;
        int pos;
        int stride;
        int ops;
        int change_at;
        modulus = table_size_q;
        if (modulus == 0) modulus = 1;
        if (modulus > MOD_MAX) modulus = MOD_MAX;
        acc       = 0;
        pos       = pair_total - 1;
        stride    = 1;
        ops       = -2;
        change_at = 2;
        while (pos >= 0) begin
            acc = (acc * 256 + pair_idx_q[pos]) % modulus;
            acc = (acc * 256 + pair_val_q[pos]) % modulus;
            ops++;
            if (ops > change_at) begin
                stride++;
                change_at += 2;
            end
            pos -= stride;
        end
        return acc[HASH_W-1:0];
    endfunction

    // Store one entry the way the block does; on the closing entry produce the hash and
    // clear the node. Returns 1 when a result is owed.
    function automatic bit absorb_entry(input logic mode, input logic [IDX_W-1:0] idx,
                                        input logic [VAL_W-1:0] val, input logic last,
                                        output node_result_t res);
        res = '0;
        if (mode || val != '0) begin
            if (pair_total < MAX_ENTRIES) begin
                pair_idx_q[pair_total] = idx;
                pair_val_q[pair_total] = val;
                pair_total++;
            end else begin
                pair_overflow = 1'b1;   // buffer full: drop the pair, flag it
            end
        end
        if (!last) return 1'b0;
        res.hash_value = fold_node_hash();
        res.overflow   = pair_overflow;
        pair_total     = 0;
        pair_overflow  = 1'b0;
        return 1'b1;
    endfunction

    // Offer one entry, hold it until the transfer, then queue what it owes.
    // A typed expectation replaces the predicted one, the predictor still advances.
    task automatic send_entry(input logic mode, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val, input logic last,
                              input logic fixed, input node_result_t fixed_res);
        int gap;
        node_result_t res;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 200) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {1'b0, val, idx};
        s_tuser  <= mode;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (absorb_entry(mode, idx, val, last, res))
            node_hash_queue.push_back(fixed ? fixed_res : res);
    endtask

    // Write table_size only once the block has drained and settled.
    task automatic write_table_size(input logic [MOD_W-1:0] value);
        s_tvalid <= 1'b0;
        while (node_hash_queue.size() != 0) @(posedge aclk);
        repeat (CFG_GUARD) @(posedge aclk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        table_size_q = value;
    endtask

    // One node of random content: mostly ascending indices and one mode, with a little
    // noise (flipped mode, out-of-order index).
    task automatic send_random_node(input int entries, input logic force_sparse);
        logic             node_mode;
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        int               pick;
        node_mode = force_sparse ? 1'b1 : 1'($urandom_range(1));
        idx = $urandom_range(1) ? IDX_W'($urandom_range(65535)) : IDX_W'($urandom_range(1023));
        for (int k = 0; k < entries; k++) begin
            mode = ($urandom_range(99) < 5) ? ~node_mode : node_mode;
            if ($urandom_range(99) < 8)
                idx = IDX_W'($urandom_range(65535));
            else if (k > 0)
                idx = idx + IDX_W'($urandom_range(1, (entries > 64) ? 3 : 300));
            pick = $urandom_range(99);
            if (pick < 20)      val = '0;
            else if (pick < 28) val = '1;
            else if (pick < 36) val = VAL_W'($urandom_range(1, 15));
            else                val = VAL_W'($urandom());
            send_entry(mode, idx, val, k == entries - 1, 1'b0, '0);
        end
    endtask

    // Receiver: check each result transfer against the oldest expectation, then pick
    // the ready level for the next cycle.
    always @(posedge aclk) begin
        node_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (node_hash_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: hash %0h overflow %0b", m_tdata, m_tuser);
                end else begin
                    want = node_hash_queue.pop_front();
                    if (m_tdata !== want.hash_value || m_tuser !== want.overflow) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected hash %0h overflow %0b, got %0h %0b",
                                     want.hash_value, want.overflow, m_tdata, m_tuser);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: abort a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [MOD_W-1:0] chunk_cfg [RAND_CHUNKS];
        node_result_t     fixed_res;
        int               chunk_items;
        int               entries;
        int               pick;

        // Hold reset, then release it for good.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: config rows drain the block first, item rows go straight in.
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].wr_cfg) begin
                write_table_size(dir_rows[r].cfg_value);
            end else begin
                fixed_res.hash_value = dir_rows[r].hash_value;
                fixed_res.overflow   = dir_rows[r].overflow;
                send_entry(dir_rows[r].mode, dir_rows[r].entry_index, dir_rows[r].entry_value,
                           dir_rows[r].last, dir_rows[r].fixed, fixed_res);
            end
        end

        // Table sizes per random chunk: reset value, both extremes, clamp cases, random.
        chunk_cfg[0] = TABLE_RESET;
        chunk_cfg[1] = MOD_W'(1);
        chunk_cfg[2] = MOD_MAX;
        chunk_cfg[3] = '1;
        chunk_cfg[4] = MOD_W'($urandom_range(1, MOD_MAX));
        chunk_cfg[5] = '0;
        chunk_cfg[6] = MOD_W'($urandom_range(2, 4096));
        chunk_cfg[7] = MOD_W'($urandom());

        for (int c = 0; c < RAND_CHUNKS; c++) begin
            write_table_size(chunk_cfg[c]);
            src_idle_pct   = src_idle_by_phase[c % 4];
            sink_stall_pct = sink_stall_by_phase[c % 4];
            if (c == BIG_CHUNK) begin
                // one node past the buffer depth; the hash covers the stored pairs only
                send_random_node(BIG_NODE, 1'b1);
            end else begin
                chunk_items = 0;
                while (chunk_items < CHUNK_ITEMS) begin
                    pick = $urandom_range(99);
                    if (pick < 10)      entries = 1;
                    else if (pick < 70) entries = $urandom_range(2, 8);
                    else if (pick < 95) entries = $urandom_range(9, 24);
                    else                entries = $urandom_range(25, 60);
                    send_random_node(entries, 1'b0);
                    chunk_items += entries;
                end
            end
        end

        // Drain: wait for every owed hash, then let the block settle.
        s_tvalid <= 1'b0;
        while (node_hash_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
